FILE: src/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);

    // Character and colour constants
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] RESET_COLOR  = 8'd15;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SETCUR = 2'd3
    } op_t;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_EXEC   = 8'b0000_0100,
        ST_SCROLL = 8'b0000_1000,
        ST_FILL   = 8'b0001_0000,
        ST_PUT    = 8'b0010_0000,
        ST_CLEAR  = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;        // capture incoming item
        logic brk;          // line break on cursor (no memory access)
        logic put;          // write character at effective cursor, advance
        logic set_cur;      // load clamped cursor
        logic rd_issue;     // read addressed cell
        logic cnt_clr;      // zero the sweep counter
        logic scroll_step;  // one step of the row-up copy
        logic fill_step;    // write one blank cell at sweep counter
        logic fill_init;    // blank uses the reset colour
        logic set_scrolled; // flag this item as having scrolled
        logic out_load;     // load the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic is_newline;
        logic col_full;
        logic last_row;
        logic scroll_end;   // sweep counter has passed the last source row
        logic cnt_last;     // sweep counter at the last cell
        logic out_free;     // output register can take a result
    } status_t;

endpackage

FILE: src/tcw_ctrl.sv
// ---------------------------------------------------------------------------
// tcw_ctrl
// Sequencing state machine: decodes each item and drives the datapath
// through writes, reads, scroll copy and screen sweeps.
// ---------------------------------------------------------------------------
module tcw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tcw_pkg::status_t status,
    output tcw_pkg::cmd_t    cmd
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                cmd.fill_step = 1'b1;
                cmd.fill_init = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC:
            begin
                unique case (status.op)
                    tcw_pkg::OP_PUT:
                    begin
                        priority if ((status.is_newline || status.col_full) &&
                                     status.last_row)
                        begin
                            cmd.cnt_clr      = 1'b1;
                            cmd.set_scrolled = 1'b1;
                            state_next       = tcw_pkg::ST_SCROLL;
                        end
                        else if (status.is_newline)
                        begin
                            cmd.brk    = 1'b1;
                            state_next = tcw_pkg::ST_EMIT;
                        end
                        else
                        begin
                            cmd.put    = 1'b1;
                            state_next = tcw_pkg::ST_EMIT;
                        end
                    end
                    tcw_pkg::OP_READ:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = tcw_pkg::ST_EMIT;
                    end
                    tcw_pkg::OP_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = tcw_pkg::ST_CLEAR;
                    end
                    tcw_pkg::OP_SETCUR:
                    begin
                        cmd.set_cur = 1'b1;
                        state_next  = tcw_pkg::ST_EMIT;
                    end
                    default:
                    begin
                        state_next = tcw_pkg::ST_EMIT;
                    end
                endcase
            end
            tcw_pkg::ST_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (status.scroll_end)
                begin
                    state_next = tcw_pkg::ST_FILL;
                end
            end
            tcw_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.cnt_last)
                begin
                    if (status.is_newline)
                    begin
                        cmd.brk    = 1'b1;
                        state_next = tcw_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = tcw_pkg::ST_PUT;
                    end
                end
            end
            tcw_pkg::ST_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = tcw_pkg::ST_EMIT;
            end
            tcw_pkg::ST_CLEAR:
            begin
                cmd.fill_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = tcw_pkg::ST_EMIT;
                end
            end
            tcw_pkg::ST_EMIT:
            begin
                // result goes out as the next item comes in
                in_ready     = status.out_free;
                cmd.out_load = status.out_free;
                cmd.latch    = status.out_free && in_valid;
                priority if (status.out_free && in_valid)
                begin
                    state_next = tcw_pkg::ST_EXEC;
                end
                else if (status.out_free)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tcw_pkg::ST_EMIT;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_INIT;
            end
        endcase
    end

endmodule

FILE: src/tcw_datapath.sv
// ---------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor, sweep counter, colour register and output register.
// ---------------------------------------------------------------------------
module tcw_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcw_pkg::cmd_t               cmd,
    output tcw_pkg::status_t            status,
    input  logic                        cfg_wr_en,
    input  logic [7:0]                  cfg_wr_data,
    input  logic [1:0]                  in_op,
    input  logic [7:0]                  in_char,
    input  logic [tcw_pkg::ADDR_W-1:0]  in_addr,
    input  logic [tcw_pkg::COL_W-1:0]   in_col,
    input  logic [tcw_pkg::ROW_W-1:0]   in_row,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [7:0]                  out_char,
    output logic [7:0]                  out_attr,
    output logic [tcw_pkg::COL_W-1:0]   out_col,
    output logic [tcw_pkg::ROW_W-1:0]   out_row,
    output logic                        out_scrolled
);

    localparam int CNT_W = tcw_pkg::CNT_W;
    localparam int MEM_W = $clog2(tcw_pkg::CELL_COUNT);

    // memory
    logic [15:0] mem [tcw_pkg::CELL_COUNT];

    // registers
    logic [7:0]                 color_reg;
    logic [1:0]                 op_reg;
    logic [7:0]                 char_reg;
    logic [tcw_pkg::ADDR_W-1:0] addr_reg;
    logic [tcw_pkg::COL_W-1:0]  ncol_reg;
    logic [tcw_pkg::ROW_W-1:0]  nrow_reg;
    logic [tcw_pkg::COL_W-1:0]  col_reg;
    logic [tcw_pkg::ROW_W-1:0]  row_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [15:0]                rd_data_reg;
    logic                       rd_ok_reg;
    logic [MEM_W-1:0]           dest_reg;
    logic                       pend_reg;
    logic                       scrolled_reg;
    logic                       out_valid_reg;
    logic [7:0]                 out_char_reg;
    logic [7:0]                 out_attr_reg;
    logic [tcw_pkg::COL_W-1:0]  out_col_reg;
    logic [tcw_pkg::ROW_W-1:0]  out_row_reg;
    logic                       out_scrolled_reg;

    // combinational
    logic                       col_full;
    logic                       last_row;
    logic                       scroll_end;
    logic [tcw_pkg::ROW_W-1:0]  eff_row;
    logic [tcw_pkg::COL_W-1:0]  eff_col;
    logic [MEM_W-1:0]           put_addr;
    logic [tcw_pkg::ROW_W-1:0]  brk_row;
    logic                       addr_ok;
    logic                       scroll_rd;
    logic                       mem_we;
    logic [MEM_W-1:0]           mem_waddr;
    logic [15:0]                mem_wdata;
    logic                       mem_re;
    logic [MEM_W-1:0]           mem_raddr;
    logic [7:0]                 blank_attr;

    assign col_full   = col_reg >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
    assign last_row   = row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    assign scroll_end = cnt_reg == CNT_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
    assign brk_row    = last_row ? row_reg : row_reg + 1'b1;
    assign eff_row    = col_full ? brk_row : row_reg;
    assign eff_col    = col_full ? '0 : col_reg;
    assign put_addr   = MEM_W'(eff_row) * MEM_W'(tcw_pkg::COLUMNS) + MEM_W'(eff_col);
    assign addr_ok    = addr_reg < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT);
    assign scroll_rd  = cmd.scroll_step && !scroll_end;
    assign blank_attr = cmd.fill_init ? tcw_pkg::RESET_COLOR : color_reg;

    // memory write port: character put, blank fill, or delayed copy write
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        priority if (cmd.put)
        begin
            mem_we    = 1'b1;
            mem_waddr = put_addr;
            mem_wdata = {color_reg, char_reg};
        end
        else if (cmd.fill_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg[MEM_W-1:0];
            mem_wdata = {blank_attr, tcw_pkg::SPACE_CODE};
        end
        else if (cmd.scroll_step && pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = dest_reg;
            mem_wdata = rd_data_reg;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    // memory read port: scroll source or addressed cell
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        priority if (scroll_rd)
        begin
            mem_re    = 1'b1;
            mem_raddr = cnt_reg[MEM_W-1:0] + MEM_W'(tcw_pkg::COLUMNS);
        end
        else if (cmd.rd_issue && addr_ok)
        begin
            mem_re    = 1'b1;
            mem_raddr = addr_reg[MEM_W-1:0];
        end
        else
        begin
            mem_re = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= in_op;
            char_reg <= in_char;
            addr_reg <= in_addr;
            ncol_reg <= in_col;
            nrow_reg <= in_row;
        end
        if (cmd.rd_issue)
        begin
            rd_ok_reg <= addr_ok;
        end
        if (scroll_rd)
        begin
            dest_reg <= cnt_reg[MEM_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_char_reg     <= (op_reg == tcw_pkg::OP_READ && rd_ok_reg) ?
                                rd_data_reg[7:0] : 8'd0;
            out_attr_reg     <= (op_reg == tcw_pkg::OP_READ && rd_ok_reg) ?
                                rd_data_reg[15:8] : 8'd0;
            out_col_reg      <= col_reg;
            out_row_reg      <= row_reg;
            out_scrolled_reg <= scrolled_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= tcw_pkg::RESET_COLOR;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            scrolled_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                color_reg <= cfg_wr_data;
            end

            priority if (cmd.put)
            begin
                col_reg <= eff_col + 1'b1;
                row_reg <= eff_row;
            end
            else if (cmd.brk)
            begin
                col_reg <= '0;
                row_reg <= brk_row;
            end
            else if (cmd.set_cur)
            begin
                col_reg <= (ncol_reg > tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) ?
                           tcw_pkg::COL_W'(tcw_pkg::COLUMNS) : ncol_reg;
                row_reg <= (nrow_reg > tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) ?
                           tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : nrow_reg;
            end
            else
            begin
                col_reg <= col_reg;
            end

            // the copy sweep stops on the first bottom-row cell, where the fill starts
            priority if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.fill_step || scroll_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg;
            end

            pend_reg <= scroll_rd;

            priority if (cmd.latch)
            begin
                scrolled_reg <= 1'b0;
            end
            else if (cmd.set_scrolled)
            begin
                scrolled_reg <= 1'b1;
            end
            else
            begin
                scrolled_reg <= scrolled_reg;
            end

            priority if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

    assign status.op         = tcw_pkg::op_t'(op_reg);
    assign status.is_newline = char_reg == tcw_pkg::NEWLINE_CODE;
    assign status.col_full   = col_full;
    assign status.last_row   = last_row;
    assign status.scroll_end = scroll_end;
    assign status.cnt_last   = cnt_reg == CNT_W'(tcw_pkg::CELL_COUNT - 1);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign out_attr     = out_attr_reg;
    assign out_col      = out_col_reg;
    assign out_row      = out_row_reg;
    assign out_scrolled = out_scrolled_reg;

endmodule

FILE: src/text_console_writer.sv
// ---------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: 25 x 80 character/colour grid with a cursor.
// ---------------------------------------------------------------------------
// Usage notes:
//   Commands arrive on the s_axis channel, one transfer per command; the
//   operation code rides in s_axis_tuser. Every command returns exactly one
//   transfer on m_axis carrying read data (read op only), the cursor after
//   the command, and a scrolled flag.
//   Colour is set through cfg_wr_en / cfg_wr_data; write it only while idle.
//   Steps (from acceptance to result in the output register):
//     put char, read cell, set cursor, newline without scroll : act, load
//     newline that scrolls : copy sweep, blank bottom row, load
//     ordinary char that wraps and scrolls : as above, with a put before load
//     clear screen : one cell write per cycle over 2000 cells, then load
//   The controller decodes and acts in its execute state and loads the
//   result in its emit state, taking the next command there when free.
//   Reset: cursor to home, colour 15, then a sweep blanks the screen;
//   s_axis_tready stays low for that time.
//   A stalled receiver holds the result in the output register; the next
//   command is taken as soon as that register is free or being drained.
// ---------------------------------------------------------------------------
module text_console_writer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: colour attribute byte
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] char_code, [18:8] cell_address, [25:19] new_column,
    // [30:26] new_line, [31] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_column,
    // [27:23] cursor_line, [28] scrolled, [31:29] zero
    output logic [31:0] m_axis_tdata
);

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t status;

    logic [7:0]                  res_char;
    logic [7:0]                  res_attr;
    logic [tcw_pkg::COL_W-1:0]   res_col;
    logic [tcw_pkg::ROW_W-1:0]   res_row;
    logic                        res_scrolled;

    // sequencing
    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and arithmetic; command fields unpacked from the stream
    tcw_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_op        (s_axis_tuser),
        .in_char      (s_axis_tdata[7:0]),
        .in_addr      (s_axis_tdata[18:8]),
        .in_col       (s_axis_tdata[25:19]),
        .in_row       (s_axis_tdata[30:26]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_char     (res_char),
        .out_attr     (res_attr),
        .out_col      (res_col),
        .out_row      (res_row),
        .out_scrolled (res_scrolled)
    );

    assign m_axis_tdata = {3'b000, res_scrolled, res_row, res_col, res_attr, res_char};

endmodule

FILE: bench/text_console_writer_test.sv
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the text console engine. Commands go in on the
// s_axis side and results come back on m_axis. A behavioural model of the
// 25 x 80 screen, the cursor and the colour register predicts each result.
// Every result is then compared field by field. A short directed plan comes
// first, then random traffic that is weighted towards line wraps and scrolls.
// The colour register is changed between phases, and both sides stall at
// random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_console_writer_test;

    // Result fields, highest bit first, laid out as on m_axis_tdata[28:0]
    typedef struct packed {
        logic       scrolled;
        logic [4:0] line;
        logic [6:0] col;
        logic [7:0] attr;
        logic [7:0] chr;
    } console_report_t;

    // One row of the directed plan; pinned rows carry a hand-written answer
    typedef struct {
        tcw_pkg::op_t    op;
        logic [7:0]      chr;
        logic [10:0]     addr;
        logic [6:0]      col;
        logic [4:0]      line;
        bit              pinned;
        console_report_t want;
    } console_step_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    // Model of the screen: colour in the high byte, character in the low byte
    logic [15:0] screen [tcw_pkg::CELL_COUNT];
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    logic [7:0]  text_colour;

    console_report_t report_fifo [$];
    console_step_t   directed_plan [$];
    int              mismatches = 0;

    // Answer that travels with the command now on the bus, if it is pinned
    bit              pin_on;
    console_report_t pin_report;

    // Idling is on while this is set; the receiver follows it too
    bit              bursty;
    int              stall_left = 0;

    text_console_writer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------

    function automatic void blank_row(int row);
        for (int c = 0; c < tcw_pkg::COLUMNS; c++)
            screen[row * tcw_pkg::COLUMNS + c] = {text_colour, tcw_pkg::SPACE_CODE};
    endfunction

    // Column to 0, then next row or scroll on the bottom row; 1 if scrolled
    function automatic bit wrap_line();
        cur_col = '0;
        if (int'(cur_row) < tcw_pkg::ROWS - 1)
        begin
            cur_row = cur_row + 5'd1;
            return 1'b0;
        end
        for (int i = 0; i + tcw_pkg::COLUMNS < tcw_pkg::CELL_COUNT; i++)
            screen[i] = screen[i + tcw_pkg::COLUMNS];
        blank_row(tcw_pkg::ROWS - 1);
        return 1'b1;
    endfunction

    function automatic console_report_t advance_console(tcw_pkg::op_t op,
                                                        logic [7:0] chr,
                                                        logic [10:0] addr,
                                                        logic [6:0] col,
                                                        logic [4:0] line);
        console_report_t rep;
        rep = '0;
        case (op)
            tcw_pkg::OP_PUT:
            begin
                if (chr == tcw_pkg::NEWLINE_CODE)
                    rep.scrolled = wrap_line();
                else
                begin
                    // a full row breaks before the character lands
                    if (int'(cur_col) >= tcw_pkg::COLUMNS)
                        rep.scrolled = wrap_line();
                    screen[int'(cur_row) * tcw_pkg::COLUMNS + int'(cur_col)] =
                        {text_colour, chr};
                    cur_col = cur_col + 7'd1;
                end
            end
            tcw_pkg::OP_READ:
            begin
                // beyond the grid reads as zero
                if (int'(addr) < tcw_pkg::CELL_COUNT)
                    {rep.attr, rep.chr} = screen[addr];
            end
            tcw_pkg::OP_CLEAR:
            begin
                for (int r = 0; r < tcw_pkg::ROWS; r++)
                    blank_row(r);
            end
            tcw_pkg::OP_SETCUR:
            begin
                cur_col = (int'(col) > tcw_pkg::COLUMNS) ? 7'(tcw_pkg::COLUMNS) : col;
                cur_row = (int'(line) > tcw_pkg::ROWS - 1) ? 5'(tcw_pkg::ROWS - 1) : line;
            end
        endcase
        rep.col  = cur_col;
        rep.line = cur_row;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_report(console_report_t owed, console_report_t seen);
        if (seen.chr !== owed.chr)
        begin
            $error("cell_char: expected %0d, got %0d", owed.chr, seen.chr);
            mismatches++;
        end
        if (seen.attr !== owed.attr)
        begin
            $error("cell_attr: expected %0d, got %0d", owed.attr, seen.attr);
            mismatches++;
        end
        if (seen.col !== owed.col)
        begin
            $error("cursor_column: expected %0d, got %0d", owed.col, seen.col);
            mismatches++;
        end
        if (seen.line !== owed.line)
        begin
            $error("cursor_line: expected %0d, got %0d", owed.line, seen.line);
            mismatches++;
        end
        if (seen.scrolled !== owed.scrolled)
        begin
            $error("scrolled: expected %0d, got %0d", owed.scrolled, seen.scrolled);
            mismatches++;
        end
    endtask

    // Everything is sampled on the rising edge. The result side is handled
    // before the command side, so a stray result is never matched against an
    // expectation queued in the same edge.
    always @(posedge clk)
    begin : watch_edges
        console_report_t seen;
        console_report_t guess;
        if (rst_n)
        begin
            if (cfg_wr_en)
                text_colour = cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata[28:0];
                if (report_fifo.size() == 0)
                begin
                    $error("result with nothing outstanding: %h", m_axis_tdata);
                    mismatches++;
                end
                else
                    check_report(report_fifo.pop_front(), seen);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                // the model always steps, so the state follows pinned rows too
                guess = advance_console(tcw_pkg::op_t'(s_axis_tuser), s_axis_tdata[7:0],
                                        s_axis_tdata[18:8], s_axis_tdata[25:19],
                                        s_axis_tdata[30:26]);
                report_fifo.push_back(pin_on ? pin_report : guess);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: back-pressure in random bursts of low-tready cycles
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            m_axis_tready = 1'b0;
        end
        else if (bursty && $urandom_range(0, 7) == 0)
        begin
            stall_left = int'($urandom_range(0, 12));
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = 1'b1;
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Drives one command at a falling edge and holds it until the transfer.
    // tvalid then stays high until an idle stretch of a call or a drain.
    task automatic send_item(tcw_pkg::op_t op, logic [7:0] chr, logic [10:0] addr,
                             logic [6:0] col, logic [4:0] line,
                             bit pinned, console_report_t want);
        @(negedge clk);
        if (bursty && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {1'b0, line, col, addr, chr};
        pin_on        = pinned;
        pin_report    = want;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Holds off commands until every owed result has come back
    task automatic drain_reports();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (report_fifo.size() != 0)
            @(posedge clk);
    endtask

    // Colour is only changed with the engine idle; waiting after the drain
    // lets the controller fall back to its idle state after the last result
    task automatic load_colour(logic [7:0] value);
        drain_reports();
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'($urandom_range(0, 255));
    endtask

    task automatic plan_step(tcw_pkg::op_t op, logic [7:0] chr, logic [10:0] addr,
                             logic [6:0] col, logic [4:0] line,
                             bit pinned, console_report_t want);
        console_step_t s;
        s.op = op; s.chr = chr; s.addr = addr; s.col = col; s.line = line;
        s.pinned = pinned; s.want = want;
        directed_plan.push_back(s);
    endtask

    function automatic console_report_t pin(logic [7:0] chr, logic [7:0] attr,
                                            logic [6:0] col, logic [4:0] line,
                                            logic scr);
        return {scr, line, col, attr, chr};
    endfunction

    // Random command, weighted towards full rows, the bottom row and reads
    // around the cursor; fields the op ignores carry noise
    task automatic draw_command(output tcw_pkg::op_t op, output logic [7:0] chr,
                                output logic [10:0] addr, output logic [6:0] col,
                                output logic [4:0] line);
        int pick;
        pick = int'($urandom_range(0, 99));
        chr  = 8'($urandom_range(0, 255));
        addr = 11'($urandom_range(0, 2047));
        col  = 7'($urandom_range(0, 127));
        line = 5'($urandom_range(0, 31));
        if (pick < 50)
            op = tcw_pkg::OP_PUT;
        else if (pick < 62)
        begin
            op  = tcw_pkg::OP_PUT;
            chr = tcw_pkg::NEWLINE_CODE;
        end
        else if (pick < 80)
        begin
            op = tcw_pkg::OP_READ;
            case ($urandom_range(0, 5))
                0, 1, 2, 3: addr = 11'($urandom_range(0, tcw_pkg::CELL_COUNT - 1));
                4:          addr = 11'(int'(cur_row) * tcw_pkg::COLUMNS +
                                       int'($urandom_range(0, tcw_pkg::COLUMNS - 1)));
                default:    addr = 11'($urandom_range(0, 2047));
            endcase
        end
        else if (pick < 82)
            op = tcw_pkg::OP_CLEAR;
        else
        begin
            op = tcw_pkg::OP_SETCUR;
            case ($urandom_range(0, 3))
                0, 1:    col = 7'($urandom_range(0, tcw_pkg::COLUMNS));
                2:       col = 7'($urandom_range(tcw_pkg::COLUMNS - 4, tcw_pkg::COLUMNS));
                default: col = 7'($urandom_range(0, 127));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: line = 5'(tcw_pkg::ROWS - 1);
                4, 5, 6:    line = 5'($urandom_range(0, tcw_pkg::ROWS - 1));
                default:    line = 5'($urandom_range(0, 31));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        tcw_pkg::op_t op;
        logic [7:0]   chr;
        logic [10:0]  addr;
        logic [6:0]   col;
        logic [4:0]   line;
        logic [7:0]   phase_colour [5];

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tcw_pkg::OP_PUT;
        pin_on        = 1'b0;
        pin_report    = '0;
        bursty        = 1'b0;

        text_colour = tcw_pkg::RESET_COLOR;
        cur_col     = '0;
        cur_row     = '0;
        for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
            screen[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::SPACE_CODE};

        // Directed plan, run at the reset colour. Pinned answers are the
        // ones that follow from reset, cursor setting or out-of-range reads.
        plan_step(tcw_pkg::OP_READ,   8'h00, 11'd0,    7'd0,   5'd0,  1'b1,
                  pin(tcw_pkg::SPACE_CODE, tcw_pkg::RESET_COLOR, 7'd0, 5'd0, 1'b0));
        plan_step(tcw_pkg::OP_READ,   8'h00, 11'd1999, 7'd0,   5'd0,  1'b1,
                  pin(tcw_pkg::SPACE_CODE, tcw_pkg::RESET_COLOR, 7'd0, 5'd0, 1'b0));
        plan_step(tcw_pkg::OP_READ,   8'h00, 11'd2000, 7'd0,   5'd0,  1'b1,
                  pin(8'h00, 8'h00, 7'd0, 5'd0, 1'b0));
        plan_step(tcw_pkg::OP_READ,   8'hFF, 11'd2047, 7'd127, 5'd31, 1'b1,
                  pin(8'h00, 8'h00, 7'd0, 5'd0, 1'b0));
        plan_step(tcw_pkg::OP_PUT,    8'h41, 11'd0,    7'd0,   5'd0,  1'b0, '0);
        plan_step(tcw_pkg::OP_PUT,    8'h00, 11'd0,    7'd0,   5'd0,  1'b0, '0);
        plan_step(tcw_pkg::OP_PUT,    8'hFF, 11'd2047, 7'd127, 5'd31, 1'b0, '0);
        plan_step(tcw_pkg::OP_READ,   8'h00, 11'd2,    7'd0,   5'd0,  1'b0, '0);
        plan_step(tcw_pkg::OP_PUT,    tcw_pkg::NEWLINE_CODE, 11'd0, 7'd0, 5'd0, 1'b0, '0);
        // clamped cursor: column saturates to a full row on the bottom line
        plan_step(tcw_pkg::OP_SETCUR, 8'h00, 11'd0,    7'd127, 5'd31, 1'b1,
                  pin(8'h00, 8'h00, 7'(tcw_pkg::COLUMNS), 5'(tcw_pkg::ROWS - 1), 1'b0));
        // full bottom row: wraps and scrolls before writing
        plan_step(tcw_pkg::OP_PUT,    8'h5A, 11'd0,    7'd0,   5'd0,  1'b0, '0);
        plan_step(tcw_pkg::OP_READ,   8'h00, 11'd1920, 7'd0,   5'd0,  1'b0, '0);
        plan_step(tcw_pkg::OP_READ,   8'h00, 11'd0,    7'd0,   5'd0,  1'b0, '0);
        plan_step(tcw_pkg::OP_SETCUR, 8'h00, 11'd0,    7'd79,  5'd24, 1'b1,
                  pin(8'h00, 8'h00, 7'd79, 5'd24, 1'b0));
        plan_step(tcw_pkg::OP_PUT,    8'h7E, 11'd0,    7'd0,   5'd0,  1'b0, '0);
        // newline on the bottom row scrolls
        plan_step(tcw_pkg::OP_PUT,    tcw_pkg::NEWLINE_CODE, 11'd0, 7'd0, 5'd0, 1'b0, '0);
        plan_step(tcw_pkg::OP_READ,   8'h00, 11'd1919, 7'd0,   5'd0,  1'b0, '0);
        plan_step(tcw_pkg::OP_SETCUR, 8'h00, 11'd0,    7'd80,  5'd0,  1'b1,
                  pin(8'h00, 8'h00, 7'd80, 5'd0, 1'b0));
        // full row above the bottom: wraps without scrolling
        plan_step(tcw_pkg::OP_PUT,    8'h31, 11'd0,    7'd0,   5'd0,  1'b0, '0);
        plan_step(tcw_pkg::OP_READ,   8'h00, 11'd80,   7'd0,   5'd0,  1'b0, '0);
        plan_step(tcw_pkg::OP_SETCUR, 8'h00, 11'd0,    7'd0,   5'd0,  1'b1,
                  pin(8'h00, 8'h00, 7'd0, 5'd0, 1'b0));
        // clear leaves the cursor where it is
        plan_step(tcw_pkg::OP_CLEAR,  8'hAA, 11'd1234, 7'd55,  5'd21, 1'b0, '0);
        plan_step(tcw_pkg::OP_READ,   8'h00, 11'd80,   7'd0,   5'd0,  1'b0, '0);
        plan_step(tcw_pkg::OP_SETCUR, 8'h00, 11'd0,    7'd0,   5'd24, 1'b1,
                  pin(8'h00, 8'h00, 7'd0, 5'd24, 1'b0));
        plan_step(tcw_pkg::OP_PUT,    tcw_pkg::NEWLINE_CODE, 11'd0, 7'd0, 5'd0, 1'b0, '0);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // tready stays low through the reset blanking sweep
        foreach (directed_plan[i])
            send_item(directed_plan[i].op, directed_plan[i].chr, directed_plan[i].addr,
                      directed_plan[i].col, directed_plan[i].line,
                      directed_plan[i].pinned, directed_plan[i].want);

        // Random phases, each at its own colour; both extremes included
        phase_colour[0] = 8'h00;
        phase_colour[1] = 8'hFF;
        phase_colour[2] = 8'($urandom_range(1, 254));
        phase_colour[3] = 8'h1E;
        phase_colour[4] = 8'($urandom_range(0, 255));

        for (int p = 0; p < 5; p++)
        begin
            load_colour(phase_colour[p]);
            for (int k = 0; k < 106; k++)
            begin
                // idling switches on and off in stretches; none at the tail
                if (k % 30 == 0)
                    bursty = $urandom_range(0, 3) != 0;
                if (p == 4 && k >= 46)
                    bursty = 1'b0;
                if (!(p == 4 && k >= 46) && $urandom_range(0, 79) == 0)
                    drain_reports();
                draw_command(op, chr, addr, col, line);
                send_item(op, chr, addr, col, line, 1'b0, '0);
            end
        end

        drain_reports();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && report_fifo.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: well beyond a run where every command scrolls and stalls
    initial
    begin
        #60_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
